FILE: hw/rtl/tcc_pkg.sv
// Package with shared types and command codes for the terminal cursor controller.
`default_nettype none

package tcc_pkg;

   localparam int CMD_W     = 8;
   localparam int PARAM_W   = 16;
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 8;
   localparam int ITEM_W    = CMD_W + 2 * PARAM_W;

   // Final bytes of the supported control sequences
   localparam logic [CMD_W-1:0] CMD_POS_H     = 8'h48; // H
   localparam logic [CMD_W-1:0] CMD_POS_F     = 8'h66; // f
   localparam logic [CMD_W-1:0] CMD_UP        = 8'h41; // A
   localparam logic [CMD_W-1:0] CMD_DOWN      = 8'h42; // B
   localparam logic [CMD_W-1:0] CMD_RIGHT     = 8'h43; // C
   localparam logic [CMD_W-1:0] CMD_LEFT      = 8'h44; // D
   localparam logic [CMD_W-1:0] CMD_NEXT_LINE = 8'h45; // E
   localparam logic [CMD_W-1:0] CMD_PREV_LINE = 8'h46; // F
   localparam logic [CMD_W-1:0] CMD_COL_G     = 8'h47; // G
   localparam logic [CMD_W-1:0] CMD_COL_GRAVE = 8'h60; // `
   localparam logic [CMD_W-1:0] CMD_ROW_ABS   = 8'h64; // d
   localparam logic [CMD_W-1:0] CMD_SAVE      = 8'h73; // s
   localparam logic [CMD_W-1:0] CMD_RESTORE   = 8'h75; // u

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_ROWS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_COLS = 8'd1;

   localparam logic [CFG_W-1:0] RST_SCREEN_ROWS = 13'd25;
   localparam logic [CFG_W-1:0] RST_SCREEN_COLS = 13'd80;

   // The command field sits in the lowest bits, param_second in the highest
   typedef struct packed {
      logic [PARAM_W-1:0] param_second;
      logic [PARAM_W-1:0] param_first;
      logic [CMD_W-1:0]   command;
   } item_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tcc_csr.sv
// Screen size registers, stored as effective sizes limited to the position range.
`default_nettype none

module tcc_csr
   import tcc_pkg::*;
#(
   parameter int POSITION_BITS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CFG_W-1:0]         csr_wdata,
   output logic [POSITION_BITS:0]        rows_size,
   output logic [POSITION_BITS:0]        cols_size
);

   localparam int SZ_W = POSITION_BITS + 1;
   localparam int CW   = (CFG_W > SZ_W) ? CFG_W : SZ_W;

   // Zero acts as one, anything above 2^POSITION_BITS acts as 2^POSITION_BITS
   function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] r);
      logic [CW-1:0] r_w;
      logic [CW-1:0] lim;
      r_w = CW'(r);
      lim = CW'(1) << POSITION_BITS;
      if (r_w == '0)
         return SZ_W'(1);
      else if (r_w > lim)
         return SZ_W'(lim);
      else
         return SZ_W'(r_w);
   endfunction

   logic [SZ_W-1:0] rows_ff, rows_in;
   logic [SZ_W-1:0] cols_ff, cols_in;
   logic            wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr && csr_index == CSR_SCREEN_ROWS) rows_in = eff_size(csr_wdata);
      if (wr && csr_index == CSR_SCREEN_COLS) cols_in = eff_size(csr_wdata);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= eff_size(RST_SCREEN_ROWS);
         cols_ff <= eff_size(RST_SCREEN_COLS);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign rows_size = rows_ff;
   assign cols_size = cols_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tcc_in_stage.sv
// Input register stage: captures one command item from the request stream.
`default_nettype none

module tcc_in_stage
   import tcc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [ITEM_W-1:0] req_tdata,
   input  wire logic              take,
   output logic                   item_valid,
   output item_type               item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     load;

   // Refill in the same cycle the held item moves on
   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_type'(req_tdata);
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tcc_exec.sv
// Cursor update logic, cursor and saved-position registers, and result register.
`default_nettype none

module tcc_exec
   import tcc_pkg::*;
#(
   parameter int POSITION_BITS = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_valid,
   input  item_type                        item,
   output logic                            take,
   input  wire logic [POSITION_BITS:0]     rows_size,
   input  wire logic [POSITION_BITS:0]     cols_size,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [POSITION_BITS-1:0]        rsp_col,
   output logic [POSITION_BITS-1:0]        rsp_row
);

   localparam int P     = POSITION_BITS;
   localparam int SZ_W  = P + 1;
   localparam int W     = (PARAM_W > SZ_W) ? PARAM_W : SZ_W;
   localparam int SUM_W = W + 1;

   function automatic logic [P-1:0] clamp_pos(input logic [W-1:0] v,
                                              input logic [SZ_W-1:0] size);
      if (v >= W'(size))
         return P'(size - SZ_W'(1));
      else
         return P'(v);
   endfunction

   function automatic logic [P-1:0] move_back(input logic [P-1:0] cur,
                                              input logic [W-1:0] n);
      if (W'(cur) >= n)
         return P'(W'(cur) - n);
      else
         return '0;
   endfunction

   function automatic logic [P-1:0] move_fwd(input logic [P-1:0] cur,
                                             input logic [W-1:0] n,
                                             input logic [SZ_W-1:0] size);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(cur) + SUM_W'(n);
      if (sum < SUM_W'(size))
         return P'(sum);
      else
         return P'(size - SZ_W'(1));
   endfunction

   logic [P-1:0] col_ff, col_in;
   logic [P-1:0] row_ff, row_in;
   logic [P-1:0] saved_col_ff, saved_col_in;
   logic [P-1:0] saved_row_ff, saved_row_in;
   logic [P-1:0] rsp_col_ff;
   logic [P-1:0] rsp_row_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [W-1:0] cnt;
   logic [W-1:0] first_abs;
   logic [W-1:0] second_abs;

   assign take         = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   // A zero count means one; a zero absolute parameter means position zero
   always_comb begin
      cnt        = (item.param_first == '0) ? W'(1) : W'(item.param_first);
      first_abs  = cnt - W'(1);
      second_abs = (item.param_second == '0) ? '0 : W'(item.param_second) - W'(1);
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      saved_col_in = saved_col_ff;
      saved_row_in = saved_row_ff;
      unique case (item.command)
         CMD_POS_H, CMD_POS_F: begin
            row_in = clamp_pos(first_abs, rows_size);
            col_in = clamp_pos(second_abs, cols_size);
         end
         CMD_UP:    row_in = move_back(row_ff, cnt);
         CMD_DOWN:  row_in = move_fwd(row_ff, cnt, rows_size);
         CMD_RIGHT: col_in = move_fwd(col_ff, cnt, cols_size);
         CMD_LEFT:  col_in = move_back(col_ff, cnt);
         CMD_NEXT_LINE: begin
            row_in = move_fwd(row_ff, cnt, rows_size);
            col_in = '0;
         end
         CMD_PREV_LINE: begin
            row_in = move_back(row_ff, cnt);
            col_in = '0;
         end
         CMD_COL_G, CMD_COL_GRAVE: col_in = clamp_pos(first_abs, cols_size);
         CMD_ROW_ABS: row_in = clamp_pos(first_abs, rows_size);
         CMD_SAVE: begin
            saved_col_in = col_ff;
            saved_row_in = row_ff;
         end
         CMD_RESTORE: begin
            col_in = clamp_pos(W'(saved_col_ff), cols_size);
            row_in = clamp_pos(W'(saved_row_ff), rows_size);
         end
         default: begin
            // unknown command: hold the cursor
            col_in = col_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         saved_col_ff <= '0;
         saved_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            saved_col_ff <= saved_col_in;
            saved_row_ff <= saved_row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_col_ff <= col_in;
         rsp_row_ff <= row_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_row   = rsp_row_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/terminal_cursor_controller_core.sv
// Path: an accepted item passes the input register, then the cursor logic into the result
// register, where the result is held until it is taken.
// Throughput: one item per cycle while the result side is ready; the cursor registers are
// updated as each item is taken, so each item sees the position the previous one left.
// Reset (synchronous, active high): cursor and saved position go to zero, screen size
// to 25 rows by 80 columns, both stages empty.
`default_nettype none

module terminal_cursor_controller_core
   import tcc_pkg::*;
#(
   parameter int POSITION_BITS = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // command[7:0], param_first[23:8], param_second[39:24]
   input  wire logic [ITEM_W-1:0]         req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // cursor_col, then cursor_row, each POSITION_BITS wide, zero padded to bytes
   output logic [((2*POSITION_BITS+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CFG_W-1:0]          csr_wdata
);

   localparam int RSP_W = ((2 * POSITION_BITS + 7) / 8) * 8;

   logic [POSITION_BITS:0]   rows_size;
   logic [POSITION_BITS:0]   cols_size;
   logic                     item_valid;
   item_type                 item;
   logic                     take;
   logic [POSITION_BITS-1:0] rsp_col;
   logic [POSITION_BITS-1:0] rsp_row;

   tcc_csr #(
      .POSITION_BITS(POSITION_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rows_size (rows_size),
      .cols_size (cols_size)
   );

   tcc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   tcc_exec #(
      .POSITION_BITS(POSITION_BITS)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rows_size  (rows_size),
      .cols_size  (cols_size),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row)
   );

   assign rsp_tdata = RSP_W'({rsp_row, rsp_col});

endmodule

`default_nettype wire

FILE: hw/rtl/tcc_checker.sv
// Port-level checks for the cursor controller, bound to the top level.
`default_nettype none

module tcc_checker #(
   parameter int POSITION_BITS = 12
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tvalid,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [((2*POSITION_BITS+7)/8)*8-1:0] rsp_tdata
);

   // No result may be pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid directly after reset");

   // With the result register empty the input side must be free
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while result register empty");

   // A fresh result follows an accepted item through the input and result registers
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without an item two cycles earlier");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind terminal_cursor_controller_core tcc_checker #(
   .POSITION_BITS(POSITION_BITS)
) u_tcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: sim/tcc_cursor_checker.sv
// Checker for the terminal cursor controller: predicts each cursor result and compares it.
`default_nettype none

module tcc_cursor_checker
   import tcc_pkg::*;
#(
   parameter int POSITION_BITS = 12,
   parameter int RSP_W         = ((2*POSITION_BITS+7)/8)*8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [ITEM_W-1:0]    req_tdata,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [RSP_W-1:0]     rsp_tdata,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   output int                        fail_count,
   output int                        outstanding
);

   localparam int unsigned POS_LIMIT = 1 << POSITION_BITS;
   localparam int PRINT_LIMIT = 20;

   typedef struct packed {
      logic [POSITION_BITS-1:0] row;
      logic [POSITION_BITS-1:0] col;
   } cursor_t;

   logic [CFG_W-1:0] screen_rows = RST_SCREEN_ROWS;
   logic [CFG_W-1:0] screen_cols = RST_SCREEN_COLS;
   int unsigned col_pos = 0, row_pos = 0, saved_col = 0, saved_row = 0;
   cursor_t expected_cursor_q[$];
   int results_seen = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Zero acts as one; anything past the position range acts as the full range
   function automatic int unsigned usable_extent(input logic [CFG_W-1:0] size);
      int unsigned s;
      s = 32'(size);
      if (s == 0)
         return 1;
      if (s > POS_LIMIT)
         return POS_LIMIT;
      return s;
   endfunction

   function automatic int unsigned clamp_pos(input int unsigned v, input int unsigned extent);
      return (v >= extent) ? extent - 1 : v;
   endfunction

   function automatic int unsigned step_back(input int unsigned cur, input int unsigned n);
      return (cur >= n) ? cur - n : 0;
   endfunction

   function automatic int unsigned step_fwd(input int unsigned cur, input int unsigned n,
                                            input int unsigned extent);
      return (cur + n < extent) ? cur + n : extent - 1;
   endfunction

   task automatic apply_command(input item_type it, output cursor_t res);
      int unsigned rows, cols, p0, p1, cnt;
      rows = usable_extent(screen_rows);
      cols = usable_extent(screen_cols);
      p0   = 32'(it.param_first);
      p1   = 32'(it.param_second);
      cnt  = (p0 == 0) ? 1 : p0;
      case (it.command)
         CMD_POS_H, CMD_POS_F: begin
            row_pos = clamp_pos(cnt - 1, rows);
            col_pos = clamp_pos((p1 == 0) ? 0 : p1 - 1, cols);
         end
         CMD_UP:    row_pos = step_back(row_pos, cnt);
         CMD_DOWN:  row_pos = step_fwd(row_pos, cnt, rows);
         CMD_RIGHT: col_pos = step_fwd(col_pos, cnt, cols);
         CMD_LEFT:  col_pos = step_back(col_pos, cnt);
         CMD_NEXT_LINE: begin
            row_pos = step_fwd(row_pos, cnt, rows);
            col_pos = 0;
         end
         CMD_PREV_LINE: begin
            row_pos = step_back(row_pos, cnt);
            col_pos = 0;
         end
         CMD_COL_G, CMD_COL_GRAVE: col_pos = clamp_pos(cnt - 1, cols);
         CMD_ROW_ABS: row_pos = clamp_pos(cnt - 1, rows);
         CMD_SAVE: begin
            saved_col = col_pos;
            saved_row = row_pos;
         end
         CMD_RESTORE: begin
            col_pos = clamp_pos(saved_col, cols);
            row_pos = clamp_pos(saved_row, rows);
         end
         default: ;
      endcase
      res.col = col_pos[POSITION_BITS-1:0];
      res.row = row_pos[POSITION_BITS-1:0];
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (fail_count < PRINT_LIMIT)
         $display("tcc_cursor_checker: result %0d %s: got %0d, expected %0d",
                  results_seen, what, got, want);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin : track
      cursor_t want, got;
      if (reset) begin
         screen_rows = RST_SCREEN_ROWS;
         screen_cols = RST_SCREEN_COLS;
         col_pos     = 0;
         row_pos     = 0;
         saved_col   = 0;
         saved_row   = 0;
         expected_cursor_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_ROWS: screen_rows = csr_wdata;
               CSR_SCREEN_COLS: screen_cols = csr_wdata;
               default: ;
            endcase
         end
         // Compare before pushing: a result in this cycle belongs to an older item
         if (rsp_tvalid && rsp_tready) begin
            got.col = rsp_tdata[POSITION_BITS-1:0];
            got.row = rsp_tdata[2*POSITION_BITS-1:POSITION_BITS];
            if (expected_cursor_q.size() == 0) begin
               report_mismatch("arrived with nothing pending, col", 32'(got.col), 0);
            end else begin
               want = expected_cursor_q.pop_front();
               if (got.col != want.col)
                  report_mismatch("cursor_col", 32'(got.col), 32'(want.col));
               if (got.row != want.row)
                  report_mismatch("cursor_row", 32'(got.row), 32'(want.row));
            end
            results_seen = results_seen + 1;
         end
         if (req_tvalid && req_tready) begin
            apply_command(item_type'(req_tdata), want);
            expected_cursor_q.push_back(want);
         end
      end
      outstanding <= expected_cursor_q.size();
   end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench top for the terminal cursor controller: stimulus, handshake pacing and verdict.
`default_nettype none

module tb;
   import tcc_pkg::*;

   localparam int POS_BITS    = 12;
   localparam int RSP_W       = ((2*POS_BITS+7)/8)*8;
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 120;
   localparam int PHASE_ITEMS = 47;
   localparam int PHASES      = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'hFF;
   // Final bytes that select no operation
   localparam logic [CMD_W-1:0] CMD_NONE_NUL = 8'h00;
   localparam logic [CMD_W-1:0] CMD_NONE_Z   = 8'h5A;
   localparam logic [CMD_W-1:0] CMD_NONE_ALL = 8'hFF;
   localparam logic [PARAM_W-1:0] PARAM_MAX  = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   item_type             req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int fail_count;
   int outstanding;
   int hold_asks = 0;
   logic [CFG_W-1:0] cur_rows = RST_SCREEN_ROWS;
   logic [CFG_W-1:0] cur_cols = RST_SCREEN_COLS;

   terminal_cursor_controller_core #(.POSITION_BITS(POS_BITS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tcc_cursor_checker #(.POSITION_BITS(POS_BITS), .RSP_W(RSP_W)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   function automatic logic [CMD_W-1:0] pick_command();
      if ($urandom_range(0, 99) < 12)
         return CMD_W'($urandom_range(0, 255));
      case ($urandom_range(0, 12))
         0:       return CMD_POS_H;
         1:       return CMD_POS_F;
         2:       return CMD_UP;
         3:       return CMD_DOWN;
         4:       return CMD_RIGHT;
         5:       return CMD_LEFT;
         6:       return CMD_NEXT_LINE;
         7:       return CMD_PREV_LINE;
         8:       return CMD_COL_G;
         9:       return CMD_COL_GRAVE;
         10:      return CMD_ROW_ABS;
         11:      return CMD_SAVE;
         default: return CMD_RESTORE;
      endcase
   endfunction

   // Keep most values near the screen size so clamps and edges get hit
   function automatic logic [PARAM_W-1:0] pick_param(input int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return PARAM_W'($urandom_range(0, 65535));
      if (r == 1)
         return PARAM_W'($urandom_range(0, 3));
      return PARAM_W'($urandom_range(0, span + 2));
   endfunction

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PARAM_W-1:0] p0,
                            input logic [PARAM_W-1:0] p1, input int gap);
      req_tdata.command      <= cmd;
      req_tdata.param_first  <= p0;
      req_tdata.param_second <= p1;
      req_tvalid             <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic set_screen(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      write_csr(CSR_SCREEN_ROWS, rows);
      write_csr(CSR_SCREEN_COLS, cols);
      cur_rows = rows;
      cur_cols = cols;
   endtask

   // Stop offering items, step once so the last accepted item is counted, then drain
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: runs of ready, short and long stalls, plus requested hold-offs
   initial begin : result_pacing
      int  run_left;
      int  hold_left;
      int  holds_taken;
      bit  run_ready;
      run_left    = 0;
      hold_left   = 0;
      holds_taken = 0;
      run_ready   = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_asks != holds_taken) begin
            holds_taken = hold_asks;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_ready = ($urandom_range(0, 1) == 1);
               run_left  = run_ready ? int'($urandom_range(1, 30)) : pick_gap();
               if (run_left == 0)
                  run_left = 1;
            end
            run_left   = run_left - 1;
            rsp_tready <= run_ready;
         end
         @(posedge clock);
      end
   end

   // Give up after a long stretch with no handshake anywhere
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
      end
      $display("tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int n;
      int gap;
      bit quiet;
      logic [CMD_W-1:0] cmd;
      logic [CFG_W-1:0] span;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on the reset screen of 25 rows by 80 columns
      send_item(CMD_POS_H, 16'd0, 16'd0, pick_gap());
      send_item(CMD_POS_H, PARAM_MAX, PARAM_MAX, pick_gap());
      send_item(CMD_SAVE, 16'd0, 16'd0, pick_gap());
      send_item(CMD_POS_F, 16'd5, 16'd10, pick_gap());
      send_item(CMD_UP, 16'd0, PARAM_MAX, pick_gap());
      send_item(CMD_UP, PARAM_MAX, 16'd0, pick_gap());
      send_item(CMD_DOWN, 16'd0, 16'd0, pick_gap());
      send_item(CMD_DOWN, PARAM_MAX, 16'd0, pick_gap());
      send_item(CMD_RIGHT, 16'd3, 16'd0, pick_gap());
      send_item(CMD_RIGHT, PARAM_MAX, 16'd0, pick_gap());
      send_item(CMD_LEFT, 16'd0, 16'd0, pick_gap());
      send_item(CMD_LEFT, PARAM_MAX, 16'd0, pick_gap());
      send_item(CMD_NEXT_LINE, 16'd2, 16'd0, pick_gap());
      send_item(CMD_PREV_LINE, 16'd0, 16'd0, pick_gap());
      send_item(CMD_PREV_LINE, PARAM_MAX, 16'd0, pick_gap());
      send_item(CMD_COL_G, 16'd0, 16'd0, pick_gap());
      send_item(CMD_COL_GRAVE, 16'd40, 16'd0, pick_gap());
      send_item(CMD_COL_G, PARAM_MAX, 16'd0, pick_gap());
      send_item(CMD_ROW_ABS, 16'd0, 16'd0, pick_gap());
      send_item(CMD_ROW_ABS, 16'd12, 16'd0, pick_gap());
      send_item(CMD_RESTORE, 16'd0, 16'd0, pick_gap());
      send_item(CMD_NONE_Z, 16'd7, 16'd9, pick_gap());
      send_item(CMD_NONE_NUL, 16'd0, 16'd0, pick_gap());
      send_item(CMD_NONE_ALL, PARAM_MAX, PARAM_MAX, pick_gap());
      send_item(CMD_NEXT_LINE, 16'd0, 16'd0, pick_gap());

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            settle();
            case (phase)
               1: set_screen(13'd4096, 13'd4096);
               2: begin
                  // Shrink hard while the cursor sits far out
                  set_screen(13'd3, 13'd5);
                  write_csr(CSR_UNUSED, '1);
               end
               3: set_screen('1, 13'd0);
               4: set_screen(13'd0, '1);
               5: set_screen(13'd1, 13'd1);
               6: set_screen(13'd4097, 13'd4095);
               7: set_screen(CFG_W'($urandom_range(1, 300)), CFG_W'($urandom_range(1, 300)));
               default: set_screen(RST_SCREEN_ROWS, RST_SCREEN_COLS);
            endcase
            csr_valid <= 1'b0;
         end
         quiet = (phase == 1) || (phase == 5);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            gap = quiet ? 0 : pick_gap();
            // Stall the result side while items keep coming so the input backs up
            if (phase == 1 && n == 8)
               hold_asks <= hold_asks + 1;
            if (n == PHASE_ITEMS - 2) begin
               send_item(CMD_POS_H, pick_param(32'(cur_rows)), pick_param(32'(cur_cols)), gap);
            end else if (n == PHASE_ITEMS - 1) begin
               send_item(CMD_SAVE, pick_param(32'(cur_rows)), pick_param(32'(cur_cols)), gap);
            end else begin
               cmd = pick_command();
               if (cmd == CMD_RIGHT || cmd == CMD_LEFT || cmd == CMD_COL_G ||
                   cmd == CMD_COL_GRAVE)
                  span = cur_cols;
               else
                  span = cur_rows;
               send_item(cmd, pick_param(32'(span)), pick_param(32'(cur_cols)), gap);
            end
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
